// ----- rtl/positional_insert_remove_list_core_assert.svh -----
// ----------------------------------------------------------------------------
// positional list core assertion macros
// shared property shapes used by the list core checks
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_REMOVE_LIST_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PIRL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pirl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirl_pkg
// constants, codes and shared types of the positional list core
// ----------------------------------------------------------------------------
package pirl_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed item field widths
  localparam int CMD_W = 3;
  localparam int POS_W = 4;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_READ       = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,  // open a gap at pos, cells above take left neighbor
    OP_DELETE = 2'd2,  // close the gap at pos, cells from pos take right neighbor
    OP_PUT    = 2'd3   // write pos, zero the cells from count up to pos
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] count;
  } cell_ctrl_t;

  // keep the low bits of an incoming value, zero above the item field
  function automatic logic [DATA_WIDTH-1:0] to_cell(input logic [VAL_W-1:0] v);
    logic [DATA_WIDTH-1:0] r;
    r = '0;
    for (int b = 0; b < DATA_WIDTH; b++) begin
      if (b < VAL_W) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

  // sign-extend or truncate a stored element to the item field
  function automatic logic [VAL_W-1:0] from_cell(input logic [DATA_WIDTH-1:0] d);
    logic [VAL_W-1:0] r;
    r = '0;
    for (int b = 0; b < VAL_W; b++) begin
      if (b < DATA_WIDTH) begin
        r[b] = d[b];
      end else begin
        r[b] = d[DATA_WIDTH-1];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/pirl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirl_cell
// one list slot: holds an element and follows the broadcast shift command
// ----------------------------------------------------------------------------
module pirl_cell (
  input  logic                            clk_i,
  input  logic [pirl_pkg::IDX_W-1:0]      cell_idx_i,
  input  pirl_pkg::cell_ctrl_t            ctrl_i,
  input  logic [pirl_pkg::DATA_WIDTH-1:0] value_i,
  input  logic [pirl_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [pirl_pkg::DATA_WIDTH-1:0] right_i,
  output logic [pirl_pkg::DATA_WIDTH-1:0] data_o,
  output logic [pirl_pkg::DATA_WIDTH-1:0] rd_o
);
  import pirl_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CMP_W-1:0]      idx;
  logic                  at_pos, above_pos, in_gap;

  assign idx       = CMP_W'(cell_idx_i);
  assign at_pos    = (idx == ctrl_i.pos);
  assign above_pos = (idx > ctrl_i.pos);
  assign in_gap    = (idx >= ctrl_i.count) && (idx < ctrl_i.pos);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (at_pos) begin
          data_d = value_i;
        end else if (above_pos) begin
          data_d = left_i;
        end
      end
      OP_DELETE: begin
        if (at_pos || above_pos) begin
          data_d = right_i;
        end
      end
      OP_PUT: begin
        if (at_pos) begin
          data_d = value_i;
        end else if (in_gap) begin
          data_d = '0;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // only the addressed cell drives the read bus
  assign rd_o   = at_pos ? data_q : '0;

endmodule

// ----- rtl/pirl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirl_ctrl
// command decode, bound checks and element count register
// ----------------------------------------------------------------------------
module pirl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [pirl_pkg::CMD_W-1:0] command_i,
  input  logic [pirl_pkg::POS_W-1:0] position_i,
  output pirl_pkg::cell_ctrl_t       ctrl_o,
  output pirl_pkg::status_e          status_o,
  output logic                       read_en_o,
  output logic [pirl_pkg::CNT_W-1:0] count_q_o,
  output logic [pirl_pkg::CNT_W-1:0] count_d_o
);
  import pirl_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] posx, cntx, capx;
  cell_op_e         op;
  logic [CMP_W-1:0] op_pos;
  status_e          status;
  logic             read_en;
  logic             is_empty, is_full;

  assign posx     = CMP_W'(position_i);
  assign cntx     = CMP_W'(count_q);
  assign capx     = CMP_W'(CAPACITY);
  assign is_empty = (count_q == '0);
  assign is_full  = (cntx == capx);

  always_comb begin
    op      = OP_HOLD;
    op_pos  = posx;
    status  = ST_OK;
    read_en = 1'b0;
    count_d = count_q;
    case (cmd_e'(command_i))
      CMD_PUSH_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          op      = OP_PUT;
          op_pos  = cntx;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          op      = OP_INSERT;
          op_pos  = '0;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          op      = OP_DELETE;
          op_pos  = '0;
          count_d = count_q - 1'b1;
        end
      end
      CMD_INSERT: begin
        if (posx >= capx) begin
          status = ST_RANGE;
        end else if (posx < cntx) begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            op      = OP_INSERT;
            count_d = count_q + 1'b1;
          end
        end else begin
          // at or past the end: zero pad up to pos
          op      = OP_PUT;
          count_d = CNT_W'(posx + 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (posx >= cntx) begin
          status = ST_RANGE;
        end else begin
          op      = OP_DELETE;
          count_d = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (posx >= cntx) begin
          status = ST_RANGE;
        end else begin
          read_en = 1'b1;
        end
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign ctrl_o.op    = accept_i ? op : OP_HOLD;
  assign ctrl_o.pos   = op_pos;
  assign ctrl_o.count = cntx;
  assign status_o     = status;
  assign read_en_o    = read_en;
  assign count_q_o    = count_q;
  assign count_d_o    = count_d;

endmodule

// ----- rtl/positional_insert_remove_list_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_remove_list_core
// fixed-capacity ordered list built as a row of shifting cells
// ----------------------------------------------------------------------------
//  channel  dir  handshake                fields
//  in       in   in_valid_i / in_ready_o  command_i, position_i, value_i
//  out      out  out_valid_o / out_ready_i read_value_o, status_o,
//                                         element_count_o, free_slots_o
//
// one item per cycle while the output is not stalled: the command is decoded and
// every cell shifts, loads or holds in the cycle the item is accepted; the result
// appears in the next cycle from the output register.
// reset clears the element count and the output valid; cell contents are not
// reset and are only read below the count.
// in_ready_o drops only while a result waits and out_ready_i is low.
// ----------------------------------------------------------------------------
`include "positional_insert_remove_list_core_assert.svh"

module positional_insert_remove_list_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pirl_pkg::CMD_W-1:0] command_i,
  input  logic [pirl_pkg::POS_W-1:0] position_i,
  input  logic [pirl_pkg::VAL_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pirl_pkg::VAL_W-1:0] read_value_o,
  output logic [pirl_pkg::ST_W-1:0]  status_o,
  output logic [pirl_pkg::CNT_W-1:0] element_count_o,
  output logic [pirl_pkg::CNT_W-1:0] free_slots_o
);
  import pirl_pkg::*;

  logic                  accept;
  cell_ctrl_t            cell_ctrl;
  status_e               status;
  logic                  read_en;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [DATA_WIDTH-1:0] value_cell;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_bus;

  logic                  out_valid_q;
  logic [VAL_W-1:0]      read_value_q;
  logic [ST_W-1:0]       status_q;
  logic [CNT_W-1:0]      element_count_q, free_slots_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign value_cell = to_cell(value_i);

  pirl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .position_i (position_i),
    .ctrl_o     (cell_ctrl),
    .status_o   (status),
    .read_en_o  (read_en),
    .count_q_o  (count_q),
    .count_d_o  (count_d)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    pirl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (cell_ctrl),
      .value_i    (value_cell),
      .left_i     (left),
      .right_i    (right),
      .data_o     (cell_data[g]),
      .rd_o       (cell_rd[g])
    );
  end

  // at most one cell matches the position
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q    <= read_en ? from_cell(rd_bus) : '0;
      status_q        <= status;
      element_count_q <= count_d;
      free_slots_q    <= CNT_W'(CAPACITY) - count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = read_value_q;
  assign status_o        = status_q;
  assign element_count_o = element_count_q;
  assign free_slots_o    = free_slots_q;

  `PIRL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY),
    "element count above capacity")
  `PIRL_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_o,
    "accepted item gave no result")
  `PIRL_ASSERT_NEXT(a_front_pop_count,
    accept && (command_i == CMD_POP_FRONT) && (count_q != '0),
    count_q == $past(count_q) - 1'b1, "pop front did not shrink the list")
  `PIRL_ASSERT_SAME(a_slots_sum, out_valid_o,
    (element_count_o + free_slots_o) == CNT_W'(CAPACITY),
    "count and free slots disagree")

endmodule
